// ----- rtl/core/pcrc_pkg.sv -----
// Package with the item types and CRC16 constants and the byte fold function.
`timescale 1ns / 1ps

package pcrc_pkg;

  // CRC16 parameters: MSB first, no reflection, no final XOR.
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Size of the trailing checksum slot, in bytes.
  localparam int CHECKSUM_BYTES = 2;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic [15:0] expected_checksum;
    logic        last_byte;
    logic [7:0]  data_byte;
  } pcrc_item_t;

  // One result item.
  typedef struct packed {
    logic [15:0] checksum;
    logic        matches_res;
  } pcrc_result_t;

  // Folds one byte into the running CRC, eight bit steps unrolled.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/pcrc_in_stage.sv -----
// Input register that holds one accepted item until the core takes it.
`timescale 1ns / 1ps

module pcrc_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pcrc_pkg::pcrc_item_t load_item,
  input  logic                advance,
  output logic                item_valid,
  output pcrc_pkg::pcrc_item_t item
);
  import pcrc_pkg::*;

  // Valid flag: set on load, cleared when the item moves on without a new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

// ----- rtl/core/pcrc_core.sv -----
// Page state (running CRC, two-byte delay line, byte counter) and result logic.
`timescale 1ns / 1ps

module pcrc_core #(
  parameter int MIN_PAGE_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  pcrc_pkg::pcrc_item_t   item,
  output pcrc_pkg::pcrc_result_t result
);
  import pcrc_pkg::*;

  localparam int CW = $clog2(MIN_PAGE_BYTES + 1);
  localparam logic [CW-1:0] MIN_COUNT  = CW'(MIN_PAGE_BYTES);
  localparam logic [CW-1:0] HOLD_COUNT = CW'(CHECKSUM_BYTES);

  logic [15:0]   crc_value;
  logic [15:0]   crc_value_next;
  logic [7:0]    held_old;
  logic [7:0]    held_new;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic [15:0]   sum;

  // Once the delay line is full, the oldest held byte is folded in.
  always_comb begin
    if (byte_count >= HOLD_COUNT) begin
      crc_value_next = crc_fold(crc_value, held_old);
    end else begin
      crc_value_next = crc_value;
    end
    if (byte_count < MIN_COUNT) begin
      byte_count_next = byte_count + CW'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  // Result for the last byte of a page; short pages report zero.
  always_comb begin
    sum = (byte_count_next >= MIN_COUNT) ? crc_value_next : 16'h0000;
    result.checksum    = sum;
    result.matches_res = (sum == item.expected_checksum);
  end

  // State update; the end of a page returns everything to its start values.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value  <= CRC_INIT;
      held_old   <= 8'h00;
      held_new   <= 8'h00;
      byte_count <= '0;
    end else if (advance) begin
      if (item.last_byte) begin
        crc_value  <= CRC_INIT;
        held_old   <= 8'h00;
        held_new   <= 8'h00;
        byte_count <= '0;
      end else begin
        crc_value  <= crc_value_next;
        held_old   <= held_new;
        held_new   <= item.data_byte;
        byte_count <= byte_count_next;
      end
    end
  end

endmodule

// ----- rtl/core/page_crc16_checker_top.sv -----
// Top level of the page CRC16 checker: stream ports, input and result registers.
`timescale 1ns / 1ps

// Page CRC16 checker. Page bytes arrive one item per cycle on the s_ side, with
// s_tlast on the final byte; the CRC16 (poly 0x8005, init 0xFFFF, MSB first)
// covers all but the last two bytes. One result item per page leaves on the
// m_ side: the checksum (zero for pages under MIN_PAGE_BYTES) and a match
// flag against the expected checksum carried with the last byte. The block
// takes one item per clock while s_tready is high. The last byte is loaded into
// the input register, and the result moves into the result register when that
// byte advances out of the input register.
// s_tready drops only while the last byte of a page waits behind a result that
// the downstream side has not yet taken.
module page_crc16_checker_top #(
  parameter int MIN_PAGE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] expected_checksum
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] checksum
  output logic [0:0]  m_tuser    // [0] matches_res
);
  import pcrc_pkg::*;

  pcrc_item_t   load_item;
  pcrc_item_t   item;
  pcrc_result_t result;
  pcrc_result_t out_result;
  logic         item_valid;
  logic         advance;
  logic         load;
  logic         out_valid;

  // Unpack the incoming item.
  always_comb begin
    load_item.data_byte         = s_tdata[7:0];
    load_item.expected_checksum = s_tdata[23:8];
    load_item.last_byte         = s_tlast;
  end

  // An item moves on unless it produces a result that cannot be stored yet.
  assign advance  = item_valid && (!item.last_byte || !out_valid || m_tready);
  assign s_tready = !item_valid || advance;
  assign load     = s_tvalid && s_tready;

  pcrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_item  (load_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pcrc_core #(
    .MIN_PAGE_BYTES (MIN_PAGE_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_result <= result;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_result.checksum;
  assign m_tuser[0] = out_result.matches_res;

endmodule

// ----- rtl/core/pcrc_checker.sv -----
// Port-level assertions for the page CRC16 checker, bound to the top level.
`timescale 1ns / 1ps

module pcrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // With no result waiting, the input side can never be blocked.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // A result being taken frees room, so the input side stays open.
  a_ready_on_drain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while the result drains");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind page_crc16_checker_top pcrc_checker u_pcrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- bench/testbench.sv -----
// Self-checking testbench for the page CRC16 checker, with a byte driver and a result monitor.
`timescale 1ns / 1ps

module testbench;

  import pcrc_pkg::*;

  localparam int MIN_PAGE = 16;

  // One page byte waiting to be offered on the input stream.
  typedef struct {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] expected_checksum;
    bit          wait_for_idle;
  } page_byte_t;

  // How the expected checksum carried by the last byte is chosen.
  typedef enum int {
    SUM_GOOD,
    SUM_ZERO,
    SUM_ONES,
    SUM_NEAR,
    SUM_RANDOM,
    SUM_GIVEN
  } sum_kind_t;

  // How the page body is filled.
  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_ALTERNATE
  } fill_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'h000000;  // [7:0] data_byte, [23:8] expected_checksum
  logic        s_tlast = 1'b0;        // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;               // [15:0] checksum
  logic [0:0]  m_tuser;               // [0] matches_res

  page_byte_t   pending_bytes[$];
  logic [7:0]   page_body[$];
  pcrc_result_t expected_sums[$];

  // Running state of the checksum predictor.
  logic [15:0] crc_acc;
  logic [7:0]  held_bytes[2];
  int          bytes_in_page;

  int error_count = 0;
  int offered_count = 0;
  int taken_count = 0;
  int results_checked = 0;
  int matches_seen = 0;
  int pages_queued = 0;
  int short_pages = 0;
  int long_pages = 0;

  // Sender burst and receiver stall bookkeeping.
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int run_left = 0;

  page_crc16_checker_top #(
    .MIN_PAGE_BYTES(MIN_PAGE)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-serial CRC-16/CMS update of one byte, most significant bit first.
  function automatic logic [15:0] crc16_cms_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc;
    for (k = 7; k >= 0; k--) begin
      if (c[15] ^ b[k]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Checksum that a correct page body carries, used to build matching pages.
  function automatic logic [15:0] page_checksum();
    logic [15:0] c;
    int i;
    c = CRC_INIT;
    if (page_body.size() < MIN_PAGE) begin
      return 16'h0000;
    end
    for (i = 0; i < page_body.size() - 2; i++) begin
      c = crc16_cms_fold(c, page_body[i]);
    end
    return c;
  endfunction

  task automatic clear_predictor();
    crc_acc = CRC_INIT;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    bytes_in_page = 0;
  endtask

  // Advances the predictor by one accepted byte and records the checksum result
  // when the byte closes a page.
  task automatic predict_byte(input logic [7:0] b, input logic last, input logic [15:0] want);
    pcrc_result_t res;
    if (bytes_in_page >= 2) begin
      crc_acc = crc16_cms_fold(crc_acc, held_bytes[0]);
    end
    held_bytes[0] = held_bytes[1];
    held_bytes[1] = b;
    if (bytes_in_page < MIN_PAGE) begin
      bytes_in_page++;
    end
    if (last) begin
      res.checksum = (bytes_in_page >= MIN_PAGE) ? crc_acc : 16'h0000;
      res.matches_res = (res.checksum == want);
      expected_sums.push_back(res);
      clear_predictor();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    error_count++;
  endtask

  // Turns the body in page_body into pending items, with the chosen checksum.
  task automatic queue_page(input sum_kind_t kind, input logic [15:0] given, input bit drain);
    logic [15:0] good;
    logic [15:0] carried;
    page_byte_t item;
    int i;
    good = page_checksum();
    case (kind)
      SUM_GOOD: begin
        carried = good;
      end
      SUM_ZERO: begin
        carried = 16'h0000;
      end
      SUM_ONES: begin
        carried = 16'hFFFF;
      end
      SUM_NEAR: begin
        carried = good ^ (16'h0001 << $urandom_range(0, 15));
      end
      SUM_RANDOM: begin
        carried = 16'($urandom_range(0, 16'hFFFF));
      end
      default: begin
        carried = given;
      end
    endcase
    for (i = 0; i < page_body.size(); i++) begin
      item.data_byte = page_body[i];
      item.last_byte = (i == page_body.size() - 1);
      item.expected_checksum = item.last_byte ? carried : 16'($urandom_range(0, 16'hFFFF));
      item.wait_for_idle = drain && (i == 0);
      pending_bytes.push_back(item);
    end
    pages_queued++;
    if (page_body.size() < MIN_PAGE) begin
      short_pages++;
    end else begin
      long_pages++;
    end
    page_body.delete();
  endtask

  // Builds one random page: mostly lengths of 4 to 30 bytes, many around the
  // minimum-size boundary, some very short pages and a few long ones.
  task automatic queue_random_page();
    int r;
    int len;
    int i;
    fill_kind_t fill;
    sum_kind_t kind;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      len = $urandom_range(1, 3);
    end else if (r < 45) begin
      len = $urandom_range(MIN_PAGE - 3, MIN_PAGE + 3);
    end else if (r < 88) begin
      len = $urandom_range(4, 30);
    end else if (r < 98) begin
      len = $urandom_range(31, 70);
    end else begin
      len = $urandom_range(71, 200);
    end
    r = $urandom_range(0, 99);
    fill = (r < 90) ? FILL_RANDOM : (r < 94) ? FILL_ZERO : (r < 97) ? FILL_ONES : FILL_ALTERNATE;
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: begin
          page_body.push_back(8'h00);
        end
        FILL_ONES: begin
          page_body.push_back(8'hFF);
        end
        FILL_ALTERNATE: begin
          page_body.push_back(i[0] ? 8'hAA : 8'h55);
        end
        default: begin
          page_body.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    r = $urandom_range(0, 99);
    kind = (r < 50) ? SUM_GOOD : (r < 60) ? SUM_ZERO : (r < 65) ? SUM_ONES :
           (r < 80) ? SUM_NEAR : SUM_RANDOM;
    queue_page(kind, 16'h0000, $urandom_range(0, 99) < 3);
  endtask

  // Stimulus, reset and end-of-run checks.
  initial begin
    int i;
    clear_predictor();

    // Directed pages: single byte, two bytes, three bytes, exactly minimum size.
    page_body.push_back(8'hFF);
    queue_page(SUM_ZERO, 16'h0000, 1'b0);
    page_body.push_back(8'h00);
    page_body.push_back(8'hFF);
    queue_page(SUM_ONES, 16'h0000, 1'b0);
    page_body.push_back(8'hFF);
    page_body.push_back(8'h00);
    page_body.push_back(8'h80);
    queue_page(SUM_GIVEN, 16'h1234, 1'b0);
    for (i = 0; i < MIN_PAGE; i++) begin
      page_body.push_back(8'(i * 17));
    end
    queue_page(SUM_GOOD, 16'h0000, 1'b0);

    // Random pages; the first one waits until the directed results are in.
    page_body.push_back(8'h01);
    queue_page(SUM_RANDOM, 16'h0000, 1'b1);
    while (pending_bytes.size() < 1800) begin
      queue_random_page();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || taken_count != offered_count) begin
      @(posedge clk);
    end
    while (expected_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (expected_sums.size() != 0) begin
      report_mismatch($sformatf("%0d checksum results never arrived", expected_sums.size()));
    end

    $display("Checked %0d pages (%0d short, %0d at or above %0d bytes) over %0d bytes.",
             pages_queued, short_pages, long_pages, MIN_PAGE, taken_count);
    $display("%0d checksum results compared, %0d of them flagged as matching.",
             results_checked, matches_seen);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // Driver: offers page bytes at the falling edge, in bursts separated by gaps.
  always @(negedge clk) begin : byte_driver
    int r;
    page_byte_t item;
    if (!rst && taken_count == offered_count) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (pending_bytes[0].wait_for_idle && expected_sums.size() != 0) begin
        s_tvalid <= 1'b0;
      end else begin
        item = pending_bytes.pop_front();
        s_tdata <= {item.expected_checksum, item.data_byte};
        s_tlast <= item.last_byte;
        s_tvalid <= 1'b1;
        offered_count++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          r = $urandom_range(0, 99);
          gap_left = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        end
      end
    end
  end

  // Receiver: ready pattern that switches among always ready, light stalls,
  // coin-flip stalls and long on/off runs.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 25);
          m_tready <= ~m_tready;
        end else begin
          run_left--;
        end
      end
    endcase
  end

  // Monitor: checks results against the oldest expectation and feeds accepted
  // bytes to the predictor.
  always @(posedge clk) begin : result_monitor
    pcrc_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("result with none pending: checksum %h match %b",
                                    m_tdata, m_tuser[0]));
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata !== want.checksum) begin
            report_mismatch($sformatf("result %0d checksum %h, expected %h",
                                      results_checked, m_tdata, want.checksum));
          end
          if (m_tuser[0] !== want.matches_res) begin
            report_mismatch($sformatf("result %0d match flag %b, expected %b",
                                      results_checked, m_tuser[0], want.matches_res));
          end
          results_checked++;
          if (want.matches_res) begin
            matches_seen++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata[7:0], s_tlast, s_tdata[23:8]);
        taken_count++;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/core/pcrc_pkg.sv
rtl/core/pcrc_in_stage.sv
rtl/core/pcrc_core.sv
rtl/core/page_crc16_checker_top.sv
rtl/core/pcrc_checker.sv
bench/testbench.sv
